// ===== hw/rtl/mcsa_pkg.sv =====
// shared constants for the monobit chi-squared accumulator core and its checker
// no dependencies
package mcsa_pkg;

    localparam int WORD_W  = 32;
    localparam int ONES_W  = 8;
    localparam int CHI_W   = 24;
    localparam int DONE_W  = 11;

    localparam int DEF_SAMPLE_BITS         = 200;
    localparam int DEF_SAMPLES_PER_SESSION = 1200;

    // deviation never exceeds ceil(254/2), so 7 bits index the score tables
    localparam int DEV_W   = 7;
    localparam int DEV_N   = 1 << DEV_W;
    localparam int SQ_W    = 2 * DEV_W;
    localparam int TQ_W    = 21;
    localparam int QUO_W   = 31;
    localparam int SLOT_W  = 3;

    localparam int CHI_SCALE = 100;

    localparam logic [CHI_W-1:0] CHI_MAX = {CHI_W{1'b1}};

endpackage

// ===== hw/rtl/monobit_chi_squared_accumulator_core.sv =====
// Monobit chi-squared accumulator core.
// A result passes from the input register through the sample stage to the output register.
// Throughput: one word per cycle while i_ready does not stall the output, set by the popcount
// stage and the score update stage, each one register deep; one result per completed sample.
// Reset: synchronous active-low i_rst_n empties the pipeline and clears the
// word slot, partial count, running score and sample count.
module monobit_chi_squared_accumulator_core #(
    parameter int SAMPLE_BITS         = mcsa_pkg::DEF_SAMPLE_BITS,
    parameter int SAMPLES_PER_SESSION = mcsa_pkg::DEF_SAMPLES_PER_SESSION
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [mcsa_pkg::WORD_W-1:0] i_word,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [mcsa_pkg::ONES_W-1:0] o_sample_ones,
    output logic [mcsa_pkg::CHI_W-1:0]  o_chi_hundredths,
    output logic [mcsa_pkg::DONE_W-1:0] o_samples_done,
    output logic                        o_session_end
);
    import mcsa_pkg::*;

    localparam int WORDS_PER_SAMPLE = (SAMPLE_BITS + 31) / 32;
    localparam int TAIL_BITS        = SAMPLE_BITS % 32;
    localparam int HALF_BITS        = SAMPLE_BITS / 2;
    localparam int CNT_W            = $clog2(SAMPLES_PER_SESSION + 1);

    localparam logic [WORD_W-1:0] TAIL_MASK = (TAIL_BITS == 0) ? {WORD_W{1'b1}} :
        WORD_W'((64'd1 << TAIL_BITS) - 64'd1);
    localparam logic [39:0] SAT_RAW = (40'hFF_FFFF * 40'd100) / HALF_BITS;
    localparam logic [CHI_W-1:0] SAT_CHI = (SAT_RAW > 40'hFF_FFFF) ? CHI_MAX :
        SAT_RAW[CHI_W-1:0];
    localparam logic [ONES_W-1:0] HALF_V = ONES_W'(HALF_BITS);
    localparam logic [CNT_W-1:0]  SESS_V = CNT_W'(SAMPLES_PER_SESSION);

    // constant score tables: d*d*100 split into quotient and remainder by the half count, and d*d
    logic [TQ_W-1:0]  w_tab_q  [DEV_N];
    logic [DEV_W-1:0] w_tab_r  [DEV_N];
    logic [SQ_W-1:0]  w_tab_sq [DEV_N];

    for (genvar d = 0; d < DEV_N; d++) begin : g_tab
        localparam int unsigned SQ     = d * d;
        localparam int unsigned SCALED = SQ * CHI_SCALE;
        assign w_tab_q[d]  = TQ_W'(SCALED / HALF_BITS);
        assign w_tab_r[d]  = DEV_W'(SCALED % HALF_BITS);
        assign w_tab_sq[d] = SQ_W'(SQ);
    end

    // input register
    logic              r_w_vld;
    logic [WORD_W-1:0] r_w;
    // sample stage
    logic              r_s_vld;
    logic [ONES_W-1:0] r_s_ones;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [ONES_W-1:0] r_partial, n_partial;
    // running score
    logic [CHI_W-1:0]  r_sum, n_sum;
    logic [QUO_W-1:0]  r_quo, n_quo;
    logic [DEV_W-1:0]  r_rem, n_rem;
    logic              r_sat, n_sat;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    // output register
    logic              r_o_vld;
    logic [ONES_W-1:0] r_o_ones;
    logic [CHI_W-1:0]  r_o_chi, n_o_chi;
    logic [DONE_W-1:0] r_o_done, n_o_done;
    logic              r_o_end, n_o_end;

    logic              w_out_rdy, w_s_rdy, w_w_rdy;
    logic              w_mv_w, w_mv_s;
    logic              w_last;
    logic [WORD_W-1:0] w_masked;
    logic [5:0]        w_pop;
    logic [ONES_W-1:0] w_ones;
    logic [ONES_W-1:0] w_diff;
    logic [DEV_W-1:0]  w_dev;
    logic [DEV_W:0]    w_rem_sum;
    logic              w_carry;
    logic [QUO_W-1:0]  w_quo;
    logic [CHI_W:0]    w_sum;
    logic [CNT_W-1:0]  w_cnt;
    logic [CNT_W+DONE_W-1:0] w_cnt_ext;
    logic              w_end;

    assign w_out_rdy = !r_o_vld || i_ready;
    assign w_s_rdy   = !r_s_vld || w_out_rdy;
    assign w_w_rdy   = !r_w_vld || w_s_rdy;
    assign w_mv_w    = r_w_vld && w_s_rdy;
    assign w_mv_s    = r_s_vld && w_out_rdy;

    assign o_ready          = w_w_rdy;
    assign o_valid          = r_o_vld;
    assign o_sample_ones    = r_o_ones;
    assign o_chi_hundredths = r_o_chi;
    assign o_samples_done   = r_o_done;
    assign o_session_end    = r_o_end;

    // popcount of the word in the input register
    always_comb begin
        w_last   = ({1'b0, r_slot} + 4'd1) >= 4'(WORDS_PER_SAMPLE);
        w_masked = w_last ? (r_w & TAIL_MASK) : r_w;
        w_pop    = '0;
        for (int i = 0; i < WORD_W; i++) begin
            w_pop = w_pop + 6'(w_masked[i]);
        end
        w_ones    = r_partial + ONES_W'(w_pop);
        n_slot    = r_slot;
        n_partial = r_partial;
        if (w_mv_w) begin
            if (w_last) begin
                n_slot    = '0;
                n_partial = '0;
            end else begin
                n_slot    = r_slot + 1'b1;
                n_partial = w_ones;
            end
        end
    end

    // score update for the sample in the sample stage
    always_comb begin
        w_diff    = (r_s_ones >= HALF_V) ? (r_s_ones - HALF_V) : (HALF_V - r_s_ones);
        w_dev     = w_diff[DEV_W-1:0];
        w_rem_sum = {1'b0, r_rem} + {1'b0, w_tab_r[w_dev]};
        w_carry   = w_rem_sum >= (DEV_W+1)'(HALF_BITS);
        w_quo     = r_quo + QUO_W'(w_tab_q[w_dev]) + QUO_W'(w_carry);
        w_sum     = {1'b0, r_sum} + (CHI_W+1)'(w_tab_sq[w_dev]);
        w_cnt     = r_cnt + 1'b1;
        w_cnt_ext = (CNT_W+DONE_W)'(w_cnt);
        w_end     = w_cnt >= SESS_V;

        n_sat = r_sat || w_sum[CHI_W];
        n_sum = w_sum[CHI_W] ? CHI_MAX : w_sum[CHI_W-1:0];
        n_quo = w_quo;
        n_rem = w_carry ? DEV_W'(w_rem_sum - (DEV_W+1)'(HALF_BITS)) : w_rem_sum[DEV_W-1:0];
        n_cnt = w_cnt;
        if (n_sat) begin
            n_o_chi = SAT_CHI;
        end else if (w_quo > QUO_W'(CHI_MAX)) begin
            n_o_chi = CHI_MAX;
        end else begin
            n_o_chi = w_quo[CHI_W-1:0];
        end
        n_o_done = w_cnt_ext[DONE_W-1:0];
        n_o_end  = w_end;
        // session end clears the running score
        if (w_end) begin
            n_sat = 1'b0;
            n_sum = '0;
            n_quo = '0;
            n_rem = '0;
            n_cnt = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_vld   <= 1'b0;
            r_s_vld   <= 1'b0;
            r_o_vld   <= 1'b0;
            r_slot    <= '0;
            r_partial <= '0;
            r_sum     <= '0;
            r_quo     <= '0;
            r_rem     <= '0;
            r_sat     <= 1'b0;
            r_cnt     <= '0;
        end else begin
            if (w_w_rdy) begin
                r_w_vld <= i_valid;
            end
            if (w_s_rdy) begin
                r_s_vld <= w_mv_w && w_last;
            end
            if (w_out_rdy) begin
                r_o_vld <= r_s_vld;
            end
            r_slot    <= n_slot;
            r_partial <= n_partial;
            if (w_mv_s) begin
                r_sum <= n_sum;
                r_quo <= n_quo;
                r_rem <= n_rem;
                r_sat <= n_sat;
                r_cnt <= n_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_w_rdy && i_valid) begin
            r_w <= i_word;
        end
        if (w_mv_w && w_last) begin
            r_s_ones <= w_ones;
        end
        if (w_mv_s) begin
            r_o_ones <= r_s_ones;
            r_o_chi  <= n_o_chi;
            r_o_done <= n_o_done;
            r_o_end  <= n_o_end;
        end
    end

endmodule

// ===== hw/rtl/mcsa_checker.sv =====
// port-level checks for the monobit chi-squared accumulator core, with its bind
// depends on mcsa_pkg and monobit_chi_squared_accumulator_core
module mcsa_checker #(
    parameter int SAMPLE_BITS         = mcsa_pkg::DEF_SAMPLE_BITS,
    parameter int SAMPLES_PER_SESSION = mcsa_pkg::DEF_SAMPLES_PER_SESSION
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic                        o_ready,
    input  logic [mcsa_pkg::WORD_W-1:0] i_word,
    input  logic                        o_valid,
    input  logic                        i_ready,
    input  logic [mcsa_pkg::ONES_W-1:0] o_sample_ones,
    input  logic [mcsa_pkg::CHI_W-1:0]  o_chi_hundredths,
    input  logic [mcsa_pkg::DONE_W-1:0] o_samples_done,
    input  logic                        o_session_end
);
    import mcsa_pkg::*;

    localparam logic [31:0] SESS_32 = 32'(SAMPLES_PER_SESSION);
    localparam logic [DONE_W-1:0] SESS_DONE = SESS_32[DONE_W-1:0];

    logic w_in_xfer;
    assign w_in_xfer = i_valid && o_ready && (i_word == i_word);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_sample_ones) &&
        $stable(o_chi_hundredths) && $stable(o_samples_done) && $stable(o_session_end))
        else $error("result changed while stalled");

    a_ones_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_sample_ones <= ONES_W'(SAMPLE_BITS))
        else $error("sample count above sample size");

    a_end_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_session_end |-> o_samples_done == SESS_DONE)
        else $error("session end at wrong sample index");

    // a result must follow a word transfer and must not appear early after reset
    a_no_early: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid ##1 (!o_valid || $past(w_in_xfer, 2)))
        else $error("result appeared too early after reset");

endmodule

bind monobit_chi_squared_accumulator_core mcsa_checker #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .SAMPLES_PER_SESSION(SAMPLES_PER_SESSION)
) u_mcsa_checker (.*);
